// ===== rtl/dns_name_label_encoder_core_assert.svh =====
// Assertion macros shared by the checker of the DNS name label encoder.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef DNS_NAME_LABEL_ENCODER_CORE_ASSERT_SVH
`define DNS_NAME_LABEL_ENCODER_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is applied.
`define DNSLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form of the clocked assertion.
`define DNSLE_ASSERT_IMPL(lbl, pre, post, msg) \
	`DNSLE_ASSERT(lbl, (pre) |-> (post), msg)

// Next-cycle implication form of the clocked assertion.
`define DNSLE_ASSERT_NEXT(lbl, pre, post, msg) \
	`DNSLE_ASSERT(lbl, (pre) |=> (post), msg)

`endif

// ===== rtl/dnsle_pkg.sv =====
// Package of the DNS name label encoder: payload types, codes and constants.
// No dependencies; used by every module of the block.
package dnsle_pkg;

	localparam int LABEL_MAX = 62;
	localparam int CNT_W = 6;

	localparam logic [7:0] DOT_CHAR = 8'h2E;
	localparam logic [7:0] TERMINATOR = 8'h00;

	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_END = 1'b1;

	typedef struct packed {
		logic op;
		logic [7:0] char_in;
	} req_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic last;
		logic label_too_long;
	} rsp_t;

	typedef enum logic [1:0] {
		EMIT_NONE,
		EMIT_LEN,
		EMIT_CHR,
		EMIT_TERM
	} emit_t;

	typedef struct packed {
		logic store;
		logic close;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic is_close;
		logic len_zero;
		logic idx_last;
		logic is_end;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/dnsle_ctrl.sv =====
// Controller state machine of the DNS name label encoder.
// Depends on dnsle_pkg; drives the datapath through cmd_t and reads status_t.
module dnsle_ctrl
	import dnsle_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input status_t status,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LEN = 4'b0010,
		ST_CHR = 4'b0100,
		ST_TERM = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd = '{store: 1'b0, close: 1'b0, emit: EMIT_NONE};
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (status.is_close) begin
						cmd.close = 1'b1;
						state_d = ST_LEN;
					end else begin
						cmd.store = 1'b1;
					end
				end
			end
			ST_LEN: begin
				if (status.out_free) begin
					cmd.emit = EMIT_LEN;
					if (!status.len_zero) begin
						state_d = ST_CHR;
					end else if (status.is_end) begin
						state_d = ST_TERM;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CHR: begin
				if (status.out_free) begin
					cmd.emit = EMIT_CHR;
					if (status.idx_last) begin
						state_d = status.is_end ? ST_TERM : ST_IDLE;
					end
				end
			end
			ST_TERM: begin
				if (status.out_free) begin
					cmd.emit = EMIT_TERM;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/dnsle_datapath.sv =====
// Datapath of the DNS name label encoder: label store, counters and output register.
// Depends on dnsle_pkg; takes cmd_t from the controller and reports status_t.
module dnsle_datapath
	import dnsle_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input req_t req,
	input cmd_t cmd,
	output status_t status,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp
);

	logic [7:0] mem [LABEL_MAX];
	logic [7:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] len_q;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_d;
	logic end_q;
	logic ovf_q;
	logic ov_q;
	rsp_t ob_q;
	logic idx_last;
	logic len_zero;

	assign len_zero = (len_q == '0);
	assign idx_last = ((idx_q + CNT_W'(1)) == len_q);

	assign status.is_close = (req.op == OP_END) || (req.char_in == DOT_CHAR);
	assign status.len_zero = len_zero;
	assign status.idx_last = idx_last;
	assign status.is_end = end_q;
	assign status.out_free = !ov_q || !rsp_stall;

	// The read address follows the next index, so rd_q always holds the entry at idx_q.
	always_comb begin
		idx_d = idx_q;
		if (cmd.close) begin
			idx_d = '0;
		end else if (cmd.emit == EMIT_CHR && !idx_last) begin
			idx_d = idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store && (count_q < CNT_W'(LABEL_MAX))) begin
			mem[count_q] <= req.char_in;
		end
		rd_q <= mem[idx_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			len_q <= '0;
			idx_q <= '0;
			end_q <= 1'b0;
			ovf_q <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (cmd.store) begin
				if (count_q < CNT_W'(LABEL_MAX)) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.close) begin
				len_q <= count_q;
				count_q <= '0;
				end_q <= (req.op == OP_END);
			end
			if (cmd.emit == EMIT_TERM) begin
				ovf_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.emit != EMIT_NONE) begin
			ov_q <= 1'b1;
		end else if (!rsp_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.emit)
			EMIT_LEN: begin
				ob_q <= '{out_byte: {{(8-CNT_W){1'b0}}, len_q},
					last: !end_q && len_zero, label_too_long: ovf_q};
			end
			EMIT_CHR: begin
				ob_q <= '{out_byte: rd_q, last: !end_q && idx_last, label_too_long: ovf_q};
			end
			EMIT_TERM: begin
				ob_q <= '{out_byte: TERMINATOR, last: 1'b1, label_too_long: ovf_q};
			end
			default: begin
				ob_q <= ob_q;
			end
		endcase
	end

	assign rsp_valid = ov_q;
	assign rsp = ob_q;

endmodule

// ===== rtl/dns_name_label_encoder_core.sv =====
// Top level of the DNS name label encoder; joins dnsle_ctrl and dnsle_datapath.
// Depends on dnsle_pkg.
//
// A host name character is taken into a 62-entry label store; characters beyond the
// store's depth are dropped and flag the rest of the name. A dot or an end-of-name
// transaction, once taken, produces its run of 1 + n bytes (2 + n for end of name) at
// one byte per cycle from the output register while the result side does not stall.
// No request is taken while a run is being produced; the single read port of the label
// store and the one-byte output register set this limit.
module dns_name_label_encoder_core
	import dnsle_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input req_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output rsp_t rsp
);

	cmd_t cmd;
	status_t status;

	dnsle_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.status(status),
		.cmd(cmd)
	);

	dnsle_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd(cmd),
		.status(status),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule

// ===== rtl/dnsle_checker.sv =====
// Port-level checker of the DNS name label encoder, bound to its top level.
// Depends on dnsle_pkg and dns_name_label_encoder_core_assert.svh.
`include "dns_name_label_encoder_core_assert.svh"

module dnsle_checker
	import dnsle_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	`DNSLE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled result changed")
	`DNSLE_ASSERT_IMPL(a_busy_in_run, rsp_valid && !rsp.last, req_stall, "request taken during a run")
	`DNSLE_ASSERT_NEXT(a_close_stalls, req_valid && !req_stall && (req.op == OP_END || req.char_in == DOT_CHAR), req_stall, "no run after a closing transaction")
	`DNSLE_ASSERT_NEXT(a_flag_steady, rsp_valid && !rsp_stall && !rsp.last, !rsp_valid || (rsp.label_too_long == $past(rsp.label_too_long)), "drop flag changed within a run")

endmodule

bind dns_name_label_encoder_core dnsle_checker u_dnsle_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req(req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp(rsp)
);

// ===== tb/sv/tb_dns_name_label_encoder_core.sv =====
// Self-checking testbench of dns_name_label_encoder_core: host names are sent one character
// per transaction and every encoded byte is compared with a label-encoding predictor.
// Depends on dnsle_pkg and the RTL of the block; needs no other file.
`timescale 1ns / 1ps

module tb_dns_name_label_encoder_core;
	import dnsle_pkg::*;

	localparam int RANDOM_REQUESTS = 100;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	logic [7:0] held_chars [LABEL_MAX];
	int held_count = 0;
	logic name_truncated = 1'b0;
	rsp_t expected_bytes [$];

	int error_count = 0;
	int requests_sent = 0;
	int idle_cycles = 0;
	int rsp_hold = 0;
	bit no_idle = 1'b0;

	dns_name_label_encoder_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Closing a label yields its length byte and then the held characters.
	function automatic void emit_label(input bit final_run);
		rsp_t r;
		r.out_byte = 8'(held_count);
		r.last = final_run && (held_count == 0);
		r.label_too_long = name_truncated;
		expected_bytes.push_back(r);
		for (int i = 0; i < held_count; i++) begin
			r.out_byte = held_chars[i];
			r.last = final_run && (i == held_count - 1);
			expected_bytes.push_back(r);
		end
		held_count = 0;
	endfunction

	function automatic void predict_encoding(input req_t item);
		rsp_t r;
		if (item.op == OP_END) begin
			emit_label(1'b0);
			r.out_byte = TERMINATOR;
			r.last = 1'b1;
			r.label_too_long = name_truncated;
			expected_bytes.push_back(r);
			name_truncated = 1'b0;
		end else if (item.char_in == DOT_CHAR) begin
			emit_label(1'b1);
		end else if (held_count < LABEL_MAX) begin
			held_chars[held_count] = item.char_in;
			held_count++;
		end else begin
			name_truncated = 1'b1;
		end
	endfunction

	function automatic logic [7:0] label_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == DOT_CHAR);
		return c;
	endfunction

	task automatic send_request(input req_t item);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 15);
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do
			@(posedge clk);
		while (req_stall);
		predict_encoding(item);
		requests_sent++;
	endtask

	task automatic send_char(input logic [7:0] c);
		req_t item;
		item.op = OP_CHAR;
		item.char_in = c;
		send_request(item);
	endtask

	task automatic send_end(input logic [7:0] c);
		req_t item;
		item.op = OP_END;
		item.char_in = c;
		send_request(item);
	endtask

	task automatic send_label(input int len);
		for (int i = 0; i < len; i++)
			send_char(label_char());
	endtask

	// The request side goes quiet until every predicted byte has been taken.
	task automatic wait_drained();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_bytes.size() != 0);
	endtask

	task automatic test_empty_names();
		send_end(8'hFF);
		send_end(DOT_CHAR);
		send_end(8'h00);
		wait_drained();
	endtask

	task automatic test_label_bytes();
		send_char(8'h00);
		send_char(8'hFF);
		send_char(8'h41);
		send_char(8'h2D);
		send_char(8'h80);
		send_char(8'h7F);
		send_char(DOT_CHAR);
		send_char(8'h01);
		send_char(8'hFE);
		send_end(8'h55);
		wait_drained();
	endtask

	task automatic test_empty_labels();
		send_char(DOT_CHAR);
		send_char(8'h61);
		send_char(DOT_CHAR);
		send_char(DOT_CHAR);
		send_char(8'h62);
		send_char(DOT_CHAR);
		send_end(8'hAA);
		wait_drained();
	endtask

	task automatic test_store_full();
		send_label(LABEL_MAX);
		send_char(DOT_CHAR);
		send_label(LABEL_MAX + 3);
		send_char(DOT_CHAR);
		send_label(2);
		send_end(8'h00);
		send_label(1);
		send_end(8'hFF);
		send_label(LABEL_MAX + 1);
		send_end(DOT_CHAR);
		wait_drained();
	endtask

	task automatic test_random_names();
		int start;
		int labels;
		int len;
		int pick;
		start = requests_sent;
		while (requests_sent - start < RANDOM_REQUESTS) begin
			no_idle = ($urandom_range(0, 5) == 0);
			pick = $urandom_range(0, 7);
			if (pick == 0) begin
				// Noise: arbitrary bytes with many dots, ended at random.
				repeat ($urandom_range(1, 8)) begin
					if ($urandom_range(0, 3) == 0)
						send_char(DOT_CHAR);
					else
						send_char(8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 1) == 1)
					send_end(8'($urandom_range(0, 255)));
			end else begin
				labels = $urandom_range(1, 4);
				for (int l = 0; l < labels; l++) begin
					pick = $urandom_range(0, 19);
					if (pick == 0)
						len = $urandom_range(LABEL_MAX - 6, LABEL_MAX + 4);
					else if (pick < 3)
						len = 0;
					else
						len = $urandom_range(1, 10);
					send_label(len);
					if (l != labels - 1)
						send_char(DOT_CHAR);
				end
				if ($urandom_range(0, 4) == 0)
					send_char(DOT_CHAR);
				send_end(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end
		no_idle = 1'b0;
		wait_drained();
	endtask

	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected byte %0h with no prediction waiting", rsp.out_byte);
				error_count++;
			end else begin
				exp_rsp = expected_bytes.pop_front();
				if (rsp.out_byte !== exp_rsp.out_byte) begin
					$error("out_byte: expected %0h, actual %0h", exp_rsp.out_byte,
						rsp.out_byte);
					error_count++;
				end
				if (rsp.last !== exp_rsp.last) begin
					$error("last: expected %0b, actual %0b", exp_rsp.last, rsp.last);
					error_count++;
				end
				if (rsp.label_too_long !== exp_rsp.label_too_long) begin
					$error("label_too_long: expected %0b, actual %0b",
						exp_rsp.label_too_long, rsp.label_too_long);
					error_count++;
				end
			end
			rsp_hold = no_idle ? 0 : $urandom_range(0, 15);
		end
		if (rsp_hold > 0) begin
			rsp_stall <= 1'b1;
			rsp_hold--;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_dns_name_label_encoder_core: errors");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_empty_names();
		test_label_bytes();
		test_empty_labels();
		test_store_full();
		test_random_names();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("tb_dns_name_label_encoder_core: clean");
		else
			$display("tb_dns_name_label_encoder_core: errors");
		$finish;
	end

endmodule
